FILE: hdl/pts_pkg.sv
// Shared types, codes and sizes of the priority task scheduler.
package pts_pkg;

  // Size of the task table
  localparam int unsigned TASK_SLOTS = 4;
  localparam int unsigned SLOT_W     = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
  localparam int unsigned CNT_W      = $clog2(TASK_SLOTS + 1);

  // Field widths of the stream payloads
  localparam int unsigned PRIO_W     = 8;
  localparam int unsigned TIME_W     = 32;
  localparam int unsigned IN_DATA_W  = 48;
  localparam int unsigned OUT_DATA_W = 80;

  // Priority that is never picked; also the start value of the best-so-far
  localparam logic [PRIO_W-1:0] PRIO_NONE = 8'd255;

  typedef enum logic [2:0] {
    ACT_TICK   = 3'd0,
    ACT_YIELD  = 3'd1,
    ACT_SLEEP  = 3'd2,
    ACT_CREATE = 3'd3,
    ACT_START  = 3'd4
  } pts_action_e;

  typedef enum logic [1:0] {
    STS_DONE    = 2'd0,
    STS_FULL    = 2'd1,
    STS_NO_TASK = 2'd2
  } pts_status_e;

  typedef enum logic [1:0] {
    SLOT_READY      = 2'd0,
    SLOT_RUNNING    = 2'd1,
    SLOT_BLOCKED    = 2'd2,
    SLOT_TERMINATED = 2'd3
  } pts_slot_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SCAN,
    ST_RELEASE,
    ST_CLAIM,
    ST_RESULT
  } pts_fsm_e;

  // Write command into the slot table (one address per cycle)
  typedef struct packed {
    logic              state_we;
    pts_slot_e         state;
    logic              prio_we;
    logic [PRIO_W-1:0] prio;
    logic              wake_we;
    logic [TIME_W-1:0] wake;
  } pts_wr_t;

  // Slot entry seen at the table address
  typedef struct packed {
    pts_slot_e         state;
    logic [PRIO_W-1:0] prio;
    logic [TIME_W-1:0] wake;
  } pts_rd_t;

endpackage

FILE: hdl/pts_slot_table.sv
// Task slot table: state, priority and wake time with one shared address.
module pts_slot_table import pts_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [SLOT_W-1:0] idx_i,
  input  pts_wr_t           wr_i,
  output pts_rd_t           rd_o
);

  pts_slot_e         state_q [TASK_SLOTS];
  logic [PRIO_W-1:0] prio_q  [TASK_SLOTS];
  logic [TIME_W-1:0] wake_q  [TASK_SLOTS];

  // Hold slot states; every slot starts terminated
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < TASK_SLOTS; i++) begin
        state_q[i] <= SLOT_TERMINATED;
      end
    end else if (wr_i.state_we) begin
      state_q[idx_i] <= wr_i.state;
    end
  end

  // Hold priority and wake time; both are written before they are read
  always_ff @(posedge clk_i) begin
    if (wr_i.prio_we) begin
      prio_q[idx_i] <= wr_i.prio;
    end
    if (wr_i.wake_we) begin
      wake_q[idx_i] <= wr_i.wake;
    end
  end

  // Read the addressed entry
  assign rd_o.state = state_q[idx_i];
  assign rd_o.prio  = prio_q[idx_i];
  assign rd_o.wake  = wake_q[idx_i];

endmodule

FILE: hdl/priority_task_scheduler_unit.sv
// Priority task scheduler: event sequencer, slot scan and result register.
//
// Each input transaction is one scheduler event (tick, yield, sleep, create,
// start) and yields exactly one output transaction. An event is accepted in
// the idle step, executed in the exec step and loaded into the result register
// in the result step; once the scheduler is started, tick, yield and sleep
// add a scan of the created tasks through a single wake/priority comparator,
// plus a release step and a claim step when the pick causes a task switch.
// The slot table has one address port, which sets the one-slot-per-cycle
// scan. The input is not ready while an event is being worked on; a finished
// result waits in the output register and the block stalls in its last step
// only if the previous result has not been taken.
module priority_task_scheduler_unit import pts_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // action[2:0], priority_req[10:3], sleep_ticks[42:11], zero[47:43]
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // status[1:0], new_task_id[3:2], running_task[5:4], switched[6],
  // task_total[9:7], uptime[41:10], switch_total[73:42], zero[79:74]
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready
);

  pts_fsm_e          state_q, state_d;

  // Captured event
  logic [2:0]        action_q, action_d;
  logic [PRIO_W-1:0] prio_q, prio_d;
  logic [TIME_W-1:0] delay_q, delay_d;

  // Scheduler state
  logic [SLOT_W-1:0] running_q, running_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [TIME_W-1:0] tick_q, tick_d;
  logic              started_q, started_d;
  logic [TIME_W-1:0] switch_total_q, switch_total_d;

  // Scan and per-event result
  logic [SLOT_W-1:0] idx_q, idx_d;
  logic [PRIO_W-1:0] best_q, best_d;
  logic [SLOT_W-1:0] sel_q, sel_d;
  pts_status_e       status_q, status_d;
  logic [SLOT_W-1:0] new_id_q, new_id_d;
  logic              sw_q, sw_d;

  // Output register
  logic [OUT_DATA_W-1:0] out_data_q, out_data_d;
  logic                  out_valid_q, out_valid_d;

  pts_wr_t tbl_wr;
  pts_rd_t tbl_rd;

  logic    in_fire;
  logic    out_free;
  logic    slot_wakes;
  logic    slot_ready;
  logic    slot_better;
  logic    scan_last;

  pts_slot_table u_slot_table (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .idx_i  (idx_q),
    .wr_i   (tbl_wr),
    .rd_o   (tbl_rd)
  );

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;

  // Shared comparator: wake check and priority compare of the addressed slot
  assign slot_wakes  = (tbl_rd.state == SLOT_BLOCKED) && (tbl_rd.wake <= tick_q);
  assign slot_ready  = (tbl_rd.state == SLOT_READY) || slot_wakes;
  assign slot_better = slot_ready && (tbl_rd.prio < best_q);
  assign scan_last   = ((CNT_W'(idx_q) + CNT_W'(1)) == cnt_q);

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_d = ST_RESULT;
        if (started_q && ((action_q == ACT_TICK) || (action_q == ACT_YIELD) ||
                          (action_q == ACT_SLEEP))) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_last) begin
          state_d = (sel_d != running_q) ? ST_RELEASE : ST_RESULT;
        end
      end
      ST_RELEASE: begin
        state_d = ST_CLAIM;
      end
      ST_CLAIM: begin
        state_d = ST_RESULT;
      end
      ST_RESULT: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Datapath and table writes per state
  always_comb begin
    action_d       = action_q;
    prio_d         = prio_q;
    delay_d        = delay_q;
    running_d      = running_q;
    cnt_d          = cnt_q;
    tick_d         = tick_q;
    started_d      = started_q;
    switch_total_d = switch_total_q;
    idx_d          = idx_q;
    best_d         = best_q;
    sel_d          = sel_q;
    status_d       = status_q;
    new_id_d       = new_id_q;
    sw_d           = sw_q;
    out_data_d     = out_data_q;
    out_valid_d    = out_valid_q;
    tbl_wr         = '0;
    tbl_wr.state   = SLOT_READY;
    tbl_wr.prio    = prio_q;

    // Drop a delivered result
    if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        // Capture the event and aim the table address at its slot
        if (in_fire) begin
          action_d = s_axis_tdata[2:0];
          prio_d   = s_axis_tdata[10:3];
          delay_d  = s_axis_tdata[42:11];
          status_d = STS_DONE;
          new_id_d = '0;
          sw_d     = 1'b0;
          priority case (s_axis_tdata[2:0])
            ACT_SLEEP:  idx_d = running_q;
            ACT_CREATE: idx_d = SLOT_W'(cnt_q);
            default:    idx_d = '0;
          endcase
        end
      end
      ST_EXEC: begin
        priority case (action_q)
          ACT_TICK: begin
            tick_d = tick_q + TIME_W'(1);
          end
          ACT_SLEEP: begin
            tbl_wr.state_we = 1'b1;
            tbl_wr.state    = SLOT_BLOCKED;
            tbl_wr.wake_we  = 1'b1;
            tbl_wr.wake     = tick_q + delay_q;
          end
          ACT_CREATE: begin
            if (cnt_q == CNT_W'(TASK_SLOTS)) begin
              status_d = STS_FULL;
            end else begin
              tbl_wr.state_we = 1'b1;
              tbl_wr.state    = SLOT_READY;
              tbl_wr.prio_we  = 1'b1;
              tbl_wr.wake_we  = 1'b1;
              tbl_wr.wake     = '0;
              new_id_d        = idx_q;
              cnt_d           = cnt_q + CNT_W'(1);
            end
          end
          ACT_START: begin
            if (cnt_q == '0) begin
              status_d = STS_NO_TASK;
            end else begin
              tbl_wr.state_we = 1'b1;
              tbl_wr.state    = SLOT_RUNNING;
              running_d       = '0;
              started_d       = 1'b1;
            end
          end
          default: begin
          end
        endcase
        // Prepare the scan from slot zero
        idx_d  = '0;
        best_d = PRIO_NONE;
        sel_d  = '0;
      end
      ST_SCAN: begin
        // Wake the slot if due, then keep it if strictly better
        if (slot_wakes) begin
          tbl_wr.state_we = 1'b1;
          tbl_wr.state    = SLOT_READY;
        end
        if (slot_better) begin
          best_d = tbl_rd.prio;
          sel_d  = idx_q;
        end
        idx_d = scan_last ? running_q : idx_q + SLOT_W'(1);
      end
      ST_RELEASE: begin
        // Return the old running slot to ready
        if (tbl_rd.state == SLOT_RUNNING) begin
          tbl_wr.state_we = 1'b1;
          tbl_wr.state    = SLOT_READY;
        end
        idx_d = sel_q;
      end
      ST_CLAIM: begin
        // Make the pick the running slot and count the switch
        tbl_wr.state_we = 1'b1;
        tbl_wr.state    = SLOT_RUNNING;
        running_d       = sel_q;
        switch_total_d  = switch_total_q + TIME_W'(1);
        sw_d            = 1'b1;
      end
      ST_RESULT: begin
        // Load the result once the output register is free
        if (out_free) begin
          out_valid_d = 1'b1;
          out_data_d  = {6'd0, switch_total_q, tick_q, 3'(cnt_q), sw_q,
                         2'(running_q), 2'(new_id_q), status_q};
        end
      end
      default: begin
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      running_q      <= '0;
      cnt_q          <= '0;
      tick_q         <= '0;
      started_q      <= 1'b0;
      switch_total_q <= '0;
      out_valid_q    <= 1'b0;
    end else begin
      state_q        <= state_d;
      running_q      <= running_d;
      cnt_q          <= cnt_d;
      tick_q         <= tick_d;
      started_q      <= started_d;
      switch_total_q <= switch_total_d;
      out_valid_q    <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    action_q   <= action_d;
    prio_q     <= prio_d;
    delay_q    <= delay_d;
    idx_q      <= idx_d;
    best_q     <= best_d;
    sel_q      <= sel_d;
    status_q   <= status_d;
    new_id_q   <= new_id_d;
    sw_q       <= sw_d;
    out_data_q <= out_data_d;
  end

  assign m_axis_tdata  = out_data_q;
  assign m_axis_tvalid = out_valid_q;

  // A started scheduler always has at least one task
  a_started_has_task: assert property (@(posedge clk_i) disable iff (!rst_ni)
    started_q |-> (cnt_q != '0))
    else $error("scheduler started with an empty task table");

  // The task count never exceeds the table size
  a_cnt_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(TASK_SLOTS))
    else $error("task count beyond table size");

  // The switch counter moves only in the claim step
  a_switch_in_claim: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (switch_total_q != $past(switch_total_q)) |-> ($past(state_q) == ST_CLAIM))
    else $error("switch counter changed outside claim step");

  // An accepted event keeps the input busy in the following cycle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> !s_axis_tready)
    else $error("input ready right after accepting an event");

endmodule

FILE: tb/sv/pts_checker.sv
// Result checker for the task scheduler: predicts each event's result and compares it.
`timescale 1ns / 1ps

module pts_checker import pts_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // action[2:0], priority_req[10:3], sleep_ticks[42:11], zero[47:43]
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  input  logic                  s_axis_tvalid,
  input  logic                  s_axis_tready,
  // status[1:0], new_task_id[3:2], running_task[5:4], switched[6],
  // task_total[9:7], uptime[41:10], switch_total[73:42], zero[79:74]
  input  logic [OUT_DATA_W-1:0] m_axis_tdata,
  input  logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output int unsigned           fail_count_o,
  output int unsigned           pending_o
);

  // Result fields, last member in the lowest bits to match the output bus
  typedef struct packed {
    logic [TIME_W-1:0] switches;
    logic [TIME_W-1:0] uptime;
    logic [CNT_W-1:0]  total;
    logic              switched;
    logic [SLOT_W-1:0] running;
    logic [SLOT_W-1:0] new_id;
    pts_status_e       status;
  } sched_result_t;

  // Shadow copy of the task table and scheduler counters
  pts_slot_e         slot_st   [TASK_SLOTS];
  logic [PRIO_W-1:0] slot_pr   [TASK_SLOTS];
  logic [TIME_W-1:0] slot_wake [TASK_SLOTS];
  logic [SLOT_W-1:0] cur_slot;
  logic [CNT_W-1:0]  n_created;
  logic [TIME_W-1:0] ticks;
  logic              started;
  logic [TIME_W-1:0] switches;

  sched_result_t expected_q [$];
  int unsigned   errs;

  assign fail_count_o = errs;

  // Wake due sleepers, pick the best ready slot and switch to it if it differs
  function automatic logic reschedule();
    logic [SLOT_W-1:0] pick;
    logic [PRIO_W-1:0] best;
    if (!started) return 1'b0;
    pick = '0;
    best = PRIO_NONE;
    for (int i = 0; i < int'(n_created); i++) begin
      if (slot_st[i] == SLOT_BLOCKED && slot_wake[i] <= ticks) slot_st[i] = SLOT_READY;
    end
    for (int i = 0; i < int'(n_created); i++) begin
      if (slot_st[i] == SLOT_READY && slot_pr[i] < best) begin
        best = slot_pr[i];
        pick = SLOT_W'(i);
      end
    end
    if (pick == cur_slot) return 1'b0;
    if (slot_st[cur_slot] == SLOT_RUNNING) slot_st[cur_slot] = SLOT_READY;
    slot_st[pick] = SLOT_RUNNING;
    cur_slot = pick;
    switches = switches + 1'b1;
    return 1'b1;
  endfunction

  // Apply one event to the shadow state and return the result it reports
  function automatic sched_result_t apply_event(input logic [2:0]        act,
                                                input logic [PRIO_W-1:0] prio,
                                                input logic [TIME_W-1:0] delay);
    sched_result_t res;
    res = '0;
    res.status = STS_DONE;
    case (act)
      ACT_TICK: begin
        ticks = ticks + 1'b1;
        res.switched = reschedule();
      end
      ACT_YIELD: begin
        res.switched = reschedule();
      end
      ACT_SLEEP: begin
        slot_wake[cur_slot] = ticks + delay;
        slot_st[cur_slot] = SLOT_BLOCKED;
        res.switched = reschedule();
      end
      ACT_CREATE: begin
        if (n_created >= TASK_SLOTS) begin
          res.status = STS_FULL;
        end else begin
          res.new_id = n_created[SLOT_W-1:0];
          slot_pr[n_created[SLOT_W-1:0]] = prio;
          slot_st[n_created[SLOT_W-1:0]] = SLOT_READY;
          slot_wake[n_created[SLOT_W-1:0]] = '0;
          n_created = n_created + 1'b1;
        end
      end
      ACT_START: begin
        if (n_created == '0) begin
          res.status = STS_NO_TASK;
        end else begin
          slot_st[0] = SLOT_RUNNING;
          cur_slot = '0;
          started = 1'b1;
        end
      end
      default: begin
        // unknown codes only report the state
      end
    endcase
    res.running  = cur_slot;
    res.total    = n_created;
    res.uptime   = ticks;
    res.switches = switches;
    return res;
  endfunction

  // Report one field mismatch
  task automatic check_field(input string name, input logic [TIME_W-1:0] exp_val,
                             input logic [TIME_W-1:0] got_val);
    if (got_val !== exp_val) begin
      $error("%s: expected %0h, got %0h", name, exp_val, got_val);
      errs++;
    end
  endtask

  // Compare finished results, then queue the prediction for each new event
  always @(posedge clk_i or negedge rst_ni) begin
    sched_result_t got;
    sched_result_t exp_res;
    if (!rst_ni) begin
      for (int i = 0; i < TASK_SLOTS; i++) begin
        slot_st[i]   = SLOT_TERMINATED;
        slot_pr[i]   = '0;
        slot_wake[i] = '0;
      end
      cur_slot  = '0;
      n_created = '0;
      ticks     = '0;
      started   = 1'b0;
      switches  = '0;
      expected_q.delete();
      errs = 0;
      pending_o <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = sched_result_t'(m_axis_tdata[$bits(sched_result_t)-1:0]);
        if (expected_q.size() == 0) begin
          $error("result transaction with no event outstanding");
          errs++;
        end else begin
          exp_res = expected_q.pop_front();
          check_field("status", TIME_W'(exp_res.status), TIME_W'(got.status));
          check_field("new_task_id", TIME_W'(exp_res.new_id), TIME_W'(got.new_id));
          check_field("running_task", TIME_W'(exp_res.running), TIME_W'(got.running));
          check_field("switched", TIME_W'(exp_res.switched), TIME_W'(got.switched));
          check_field("task_total", TIME_W'(exp_res.total), TIME_W'(got.total));
          check_field("uptime", exp_res.uptime, got.uptime);
          check_field("switch_total", exp_res.switches, got.switches);
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        expected_q.push_back(apply_event(s_axis_tdata[2:0], s_axis_tdata[10:3],
                                         s_axis_tdata[42:11]));
      end
      pending_o <= expected_q.size();
    end
  end

endmodule

FILE: tb/sv/tb.sv
// Testbench top for the task scheduler: clock, reset, event stimulus and verdict.
`timescale 1ns / 1ps

module tb;
  import pts_pkg::*;

  localparam int unsigned ITEM_TARGET    = 1360;
  localparam int unsigned IDLE_PCT       = 11;
  localparam int unsigned CALM_FROM      = 500;
  localparam int unsigned CALM_TO        = 800;
  localparam int unsigned HOLD_AT        = 300;
  localparam int unsigned HOLD_CYCLES    = 400;
  localparam int unsigned PAUSE_AT       = 1000;
  localparam int unsigned TAIL_CYCLES    = 30;
  localparam int unsigned WATCHDOG_LIMIT = 5000;
  localparam logic [2:0]  ACT_CODE_MAX   = '1;

  logic                  clk_i;
  logic                  rst_ni;
  logic [IN_DATA_W-1:0]  s_axis_tdata;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  int unsigned           fail_count;
  int unsigned           pending;

  bit          calm;
  bit          hold_req;
  bit          hold_done;
  int unsigned quiet_cycles;

  priority_task_scheduler_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready)
  );

  pts_checker checker_i (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .fail_count_o  (fail_count),
    .pending_o     (pending)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Offer one event, with random idle cycles ahead of it outside the calm stretch, and hold until accepted
  task automatic issue(input logic [2:0] act, input logic [PRIO_W-1:0] prio,
                       input logic [TIME_W-1:0] delay);
    if (!calm) begin
      while ($urandom_range(99) < IDLE_PCT) begin
        s_axis_tvalid <= 1'b0;
        @(posedge clk_i);
      end
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(IN_DATA_W - 3 - PRIO_W - TIME_W){1'b0}}, delay, prio, act};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // Stop offering and wait until every outstanding result has been taken
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  // Mostly short sleeps so tasks keep waking; near-max delays wrap to the past
  function automatic logic [TIME_W-1:0] pick_delay();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 55) return TIME_W'($urandom_range(0, 6));
    if (r < 80) return TIME_W'($urandom_range(7, 40));
    if (r < 88) return TIME_W'($urandom_range(41, 200));
    return ~TIME_W'($urandom_range(0, 2));
  endfunction

  // Stimulus and verdict
  initial begin
    int unsigned counted;
    int unsigned r;
    logic [2:0]  act;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    rst_ni        <= 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed events: empty table, fill-up, start, ties, wrap and repeated start
    issue(ACT_TICK, 8'h00, '0);
    issue(ACT_SLEEP, 8'h00, '1);
    issue(ACT_START, 8'h00, '0);
    issue(ACT_YIELD, 8'h00, '0);
    issue(ACT_CODE_MAX, 8'hFF, '1);
    issue(ACT_CREATE, PRIO_NONE, '0);
    issue(ACT_CREATE, 8'h00, '0);
    issue(ACT_SLEEP, 8'h00, 32'd3);
    issue(ACT_TICK, 8'h00, '0);
    issue(ACT_START, 8'h00, '0);
    issue(ACT_CREATE, 8'h07, '0);
    issue(ACT_YIELD, 8'h00, '0);
    issue(ACT_CREATE, 8'h07, '0);
    issue(ACT_CREATE, 8'hAA, '0);
    issue(ACT_SLEEP, 8'h00, 32'd2);
    issue(ACT_TICK, 8'h00, '0);
    issue(ACT_TICK, 8'h00, '0);
    issue(ACT_SLEEP, 8'h00, '0);
    issue(ACT_SLEEP, 8'h00, '1);
    issue(ACT_SLEEP, 8'h00, 32'd20);
    issue(ACT_SLEEP, 8'h00, 32'd20);
    issue(ACT_YIELD, 8'h00, '0);
    issue(ACT_START, 8'h00, '0);
    issue(ACT_YIELD, 8'h00, '0);
    issue(ACT_START + 3'd1, 8'h55, 32'h5555_5555);

    // Random events; creates and unknown codes are not counted
    counted = 0;
    while (counted < ITEM_TARGET) begin
      calm = (counted >= CALM_FROM) && (counted < CALM_TO);
      r = $urandom_range(99);
      if (r < 38) begin
        issue(ACT_TICK, PRIO_W'($urandom_range(255)), '0);
        counted++;
      end else if (r < 55) begin
        issue(ACT_YIELD, '0, TIME_W'($urandom()));
        counted++;
      end else if (r < 85) begin
        issue(ACT_SLEEP, '0, pick_delay());
        counted++;
      end else if (r < 89) begin
        issue(ACT_START, '0, '0);
        counted++;
      end else if (r < 96) begin
        issue(ACT_CREATE, PRIO_W'($urandom_range(255)), '0);
      end else begin
        act = 3'($urandom_range(ACT_START + 1, ACT_CODE_MAX));
        issue(act, PRIO_W'($urandom_range(255)), TIME_W'($urandom()));
      end
      if (counted == HOLD_AT) hold_req = 1'b1;
      if (counted == PAUSE_AT && r < 89) drain();
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Result side: random stalls, calm stretch, and one long hold-off
  initial begin
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else begin
        m_axis_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // End the run when no transaction moves for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
